// ===== rtl/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared constants, codes and types of the circle/polygon collision block.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int CNT_W    = 6;      // vertex count, holds up to 63
    localparam int IDX_W    = 5;      // reported edge index width
    localparam int COORD_W  = 32;
    localparam int RAD_W    = 31;
    localparam int DIFF_W   = 33;
    localparam int OPW      = 68;     // multiplier operand width (signed)
    localparam int PW       = 2 * OPW; // product / accumulator width
    localparam int MCNT_W   = 7;      // multiplier step counter

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    // multiplier operand pairs
    localparam logic [3:0] SEL_R2    = 4'd0;  // r * r
    localparam logic [3:0] SEL_DXDX  = 4'd1;
    localparam logic [3:0] SEL_DYDY  = 4'd2;
    localparam logic [3:0] SEL_WXDX  = 4'd3;
    localparam logic [3:0] SEL_WYDY  = 4'd4;
    localparam logic [3:0] SEL_WXWX  = 4'd5;
    localparam logic [3:0] SEL_WYWY  = 4'd6;
    localparam logic [3:0] SEL_EXEX  = 4'd7;
    localparam logic [3:0] SEL_EYEY  = 4'd8;
    localparam logic [3:0] SEL_WXDY  = 4'd9;
    localparam logic [3:0] SEL_WYDX  = 4'd10;
    localparam logic [3:0] SEL_CRCR  = 4'd11;
    localparam logic [3:0] SEL_R2LEN = 4'd12;

    // product destinations
    localparam logic [1:0] DST_A  = 2'd0;
    localparam logic [1:0] DST_B  = 2'd1;
    localparam logic [1:0] DST_C  = 2'd2;
    localparam logic [1:0] DST_R2 = 2'd3;

    // accumulate modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_SUB  = 2'd2;

    typedef struct packed {
        logic             mem_we;
        logic [CNT_W-1:0] mem_waddr;
        logic [CNT_W-1:0] rd_addr;
        logic             ld_i;
        logic             ld_j;
        logic             ld_circle;
        logic             mul_start;
        logic [3:0]       mul_sel;
        logic [1:0]       mul_dst;
        logic [1:0]       mul_mode;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic straddle;   // edge crosses the horizontal line through the centre
        logic d_pos;      // yj - yi > 0
        logic a_lt_b;
        logic b_lt_a;
        logic a_le0;
        logic b_le0;
        logic r2_lt_c;
    } dp_sts_t;

    typedef struct packed {
        logic             is_edge_hit;
        logic [IDX_W-1:0] edge_start;
        logic [IDX_W-1:0] edge_end;
        logic             centre_inside;
        logic             collides;
        logic             overflowed;
        logic             last;
    } out_item_t;

endpackage

// ===== rtl/cpc_mul.sv =====
// ----------------------------------------------------------------------------
// cpc_mul
// Signed 68x68 shift-add multiplier, one partial product bit per cycle.
// ----------------------------------------------------------------------------
module cpc_mul import cpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [OPW-1:0] a,
    input  logic signed [OPW-1:0] b,
    output logic                  done,
    output logic signed [PW-1:0]  p
);

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    logic              done_reg, done_next;
    logic [MCNT_W-1:0] cnt_reg, cnt_next;
    logic [OPW-1:0]    ma_reg;
    logic [PW-1:0]     prod_reg;
    logic              neg_reg;
    logic [PW-1:0]     p_reg;
    logic [OPW:0]      sum;

    assign sum = {1'b0, prod_reg[PW-1:OPW]} + (prod_reg[0] ? {1'b0, ma_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MCNT_W'(OPW - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        if (fin_reg)
            done_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg   <= a[OPW-1] ? OPW'(-a) : OPW'(a);
            prod_reg <= {{OPW{1'b0}}, (b[OPW-1] ? OPW'(-b) : OPW'(b))};
            neg_reg  <= a[OPW-1] ^ b[OPW-1];
        end
        else if (busy_reg)
            prod_reg <= {sum, prod_reg[OPW-1:1]};
        if (fin_reg)
            p_reg <= neg_reg ? PW'(-prod_reg) : prod_reg;
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// ===== rtl/cpc_datapath.sv =====
// ----------------------------------------------------------------------------
// cpc_datapath
// Vertex store, edge operand registers, shared multiplier and accumulators.
// ----------------------------------------------------------------------------
module cpc_datapath import cpc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic [RAD_W-1:0]          radius,
    output dp_sts_t                   sts
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [2*COORD_W-1:0] mem [MAX_VERTICES];
    logic [2*COORD_W-1:0] mem_q;

    logic signed [COORD_W-1:0] px_reg, py_reg, xi_reg, yi_reg, xj_reg, yj_reg;
    logic [RAD_W-1:0]          r_reg;
    logic signed [PW-1:0]      acc_a_reg, acc_b_reg, acc_c_reg, r2_reg;
    logic [1:0]                dst_reg, mode_reg;

    logic signed [DIFF_W-1:0] wx, wy, dx, dy, ex, ey;
    logic signed [OPW-1:0]    opa, opb;
    logic                     mul_done;
    logic signed [PW-1:0]     prod, acc_sel, acc_new;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[cmd.mem_waddr[AW-1:0]] <= {coord_y, coord_x};
        mem_q <= mem[cmd.rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_circle)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
            r_reg  <= radius;
        end
        if (cmd.ld_i)
        begin
            xi_reg <= mem_q[COORD_W-1:0];
            yi_reg <= mem_q[2*COORD_W-1:COORD_W];
        end
        if (cmd.ld_j)
        begin
            xj_reg <= mem_q[COORD_W-1:0];
            yj_reg <= mem_q[2*COORD_W-1:COORD_W];
        end
        if (cmd.mul_start)
        begin
            dst_reg  <= cmd.mul_dst;
            mode_reg <= cmd.mul_mode;
        end
    end

    // edge from start vertex i to end vertex j
    assign wx = DIFF_W'(px_reg) - DIFF_W'(xi_reg);
    assign wy = DIFF_W'(py_reg) - DIFF_W'(yi_reg);
    assign dx = DIFF_W'(xj_reg) - DIFF_W'(xi_reg);
    assign dy = DIFF_W'(yj_reg) - DIFF_W'(yi_reg);
    assign ex = DIFF_W'(px_reg) - DIFF_W'(xj_reg);
    assign ey = DIFF_W'(py_reg) - DIFF_W'(yj_reg);

    always_comb
    begin
        opa = '0;
        opb = '0;
        case (cmd.mul_sel)
            SEL_R2:    begin opa = OPW'({1'b0, r_reg}); opb = OPW'({1'b0, r_reg}); end
            SEL_DXDX:  begin opa = OPW'(dx); opb = OPW'(dx); end
            SEL_DYDY:  begin opa = OPW'(dy); opb = OPW'(dy); end
            SEL_WXDX:  begin opa = OPW'(wx); opb = OPW'(dx); end
            SEL_WYDY:  begin opa = OPW'(wy); opb = OPW'(dy); end
            SEL_WXWX:  begin opa = OPW'(wx); opb = OPW'(wx); end
            SEL_WYWY:  begin opa = OPW'(wy); opb = OPW'(wy); end
            SEL_EXEX:  begin opa = OPW'(ex); opb = OPW'(ex); end
            SEL_EYEY:  begin opa = OPW'(ey); opb = OPW'(ey); end
            SEL_WXDY:  begin opa = OPW'(wx); opb = OPW'(dy); end
            SEL_WYDX:  begin opa = OPW'(wy); opb = OPW'(dx); end
            SEL_CRCR:  begin opa = acc_c_reg[OPW-1:0]; opb = acc_c_reg[OPW-1:0]; end
            SEL_R2LEN: begin opa = r2_reg[OPW-1:0]; opb = acc_a_reg[OPW-1:0]; end
            default:   begin opa = '0; opb = '0; end
        endcase
    end

    cpc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .p     (prod)
    );

    always_comb
    begin
        unique case (dst_reg)
            DST_A:   acc_sel = acc_a_reg;
            DST_B:   acc_sel = acc_b_reg;
            DST_C:   acc_sel = acc_c_reg;
            default: acc_sel = r2_reg;
        endcase
        case (mode_reg)
            MODE_ADD: acc_new = acc_sel + prod;
            MODE_SUB: acc_new = acc_sel - prod;
            default:  acc_new = prod;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            unique case (dst_reg)
                DST_A:   acc_a_reg <= acc_new;
                DST_B:   acc_b_reg <= acc_new;
                DST_C:   acc_c_reg <= acc_new;
                default: r2_reg    <= acc_new;
            endcase
        end
    end

    always_comb
    begin
        sts.mul_done = mul_done;
        sts.straddle = (yi_reg > py_reg) != (yj_reg > py_reg);
        sts.d_pos    = dy > 0;
        sts.a_lt_b   = acc_a_reg < acc_b_reg;
        sts.b_lt_a   = acc_b_reg < acc_a_reg;
        sts.a_le0    = acc_a_reg <= 0;
        sts.b_le0    = acc_b_reg <= 0;
        sts.r2_lt_c  = r2_reg < acc_c_reg;
    end

endmodule

// ===== rtl/cpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpc_ctrl
// Sequencer: store bookkeeping, containment pass, edge pass, result emission.
// ----------------------------------------------------------------------------
module cpc_ctrl import cpc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [1:0] in_op,
    output logic      in_ready,
    input  logic      out_free,
    output logic      out_load,
    output out_item_t out_item,
    output dp_cmd_t   cmd,
    input  dp_sts_t   sts
);

    localparam logic [4:0] S_IDLE = 5'd0,  S_R2   = 5'd1,  S_WAIT = 5'd2,  S_LOOP = 5'd3,
                           S_RDI  = 5'd4,  S_RDJ  = 5'd5,  S_LDJ  = 5'd6,  S_DSP  = 5'd7,
                           S_CT0  = 5'd8,  S_CT1  = 5'd9,  S_CT2  = 5'd10, S_E0   = 5'd11,
                           S_E1   = 5'd12, S_E2   = 5'd13, S_E3   = 5'd14, S_E4   = 5'd15,
                           S_P0   = 5'd16, S_P1   = 5'd17, S_Q0   = 5'd18, S_Q1   = 5'd19,
                           S_X0   = 5'd20, S_X1   = 5'd21, S_X2   = 5'd22, S_X3   = 5'd23,
                           S_X4   = 5'd24, S_PCHK = 5'd25, S_HIT  = 5'd26, S_NEXT = 5'd27,
                           S_VERD = 5'd28;

    localparam logic [CNT_W-1:0] MAXV = CNT_W'(MAX_VERTICES);

    logic [4:0]       state_reg, state_next, after_reg, after_next;
    logic [CNT_W-1:0] count_reg, count_next, n_reg, n_next, i_reg, i_next, j;
    logic             ovf_reg, ovf_next, phase_reg, phase_next;   // phase 1: edge pass
    logic             inside_reg, inside_next, any_reg, any_next;

    assign j = (i_reg == '0) ? n_reg - 1'b1 : i_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        after_next  = after_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        ovf_next    = ovf_reg;
        phase_next  = phase_reg;
        inside_next = inside_reg;
        any_next    = any_reg;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        out_item    = '0;
        cmd         = '0;
        cmd.mem_waddr = count_reg;
        cmd.rd_addr   = i_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < MAXV)
                            begin
                                cmd.mem_we = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                                ovf_next = 1'b1;
                        end
                        OP_TEST:
                        begin
                            cmd.ld_circle = 1'b1;
                            n_next      = count_reg;
                            i_next      = '0;
                            phase_next  = 1'b0;
                            inside_next = 1'b0;
                            any_next    = 1'b0;
                            state_next  = S_R2;
                        end
                        default: ;
                    endcase
                end
            end
            S_R2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_R2;
                cmd.mul_dst   = DST_R2;
                after_next    = S_LOOP;
                state_next    = S_WAIT;
            end
            S_WAIT:
                if (sts.mul_done)
                    state_next = after_reg;
            S_LOOP:
            begin
                if (i_reg == n_reg)
                begin
                    if (phase_reg || inside_reg)
                        state_next = S_VERD;
                    else
                    begin
                        phase_next = 1'b1;
                        i_next     = '0;
                    end
                end
                else
                    state_next = S_RDI;
            end
            S_RDI:
                state_next = S_RDJ;
            S_RDJ:
            begin
                cmd.rd_addr = j;
                cmd.ld_i    = 1'b1;
                state_next  = S_LDJ;
            end
            S_LDJ:
            begin
                cmd.ld_j   = 1'b1;
                state_next = S_DSP;
            end
            S_DSP:
                state_next = phase_reg ? S_E0 : (sts.straddle ? S_CT0 : S_NEXT);
            S_CT0:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_WXDY;
                cmd.mul_dst   = DST_A;
                after_next    = S_CT1;
                state_next    = S_WAIT;
            end
            S_CT1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_WYDX;
                cmd.mul_dst   = DST_B;
                after_next    = S_CT2;
                state_next    = S_WAIT;
            end
            S_CT2:
            begin
                if (sts.d_pos ? sts.a_lt_b : sts.b_lt_a)
                    inside_next = !inside_reg;
                state_next = S_NEXT;
            end
            S_E0:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_DXDX;
                cmd.mul_dst   = DST_A;
                after_next    = S_E1;
                state_next    = S_WAIT;
            end
            S_E1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_DYDY;
                cmd.mul_dst   = DST_A;
                cmd.mul_mode  = MODE_ADD;
                after_next    = S_E2;
                state_next    = S_WAIT;
            end
            S_E2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_WXDX;
                cmd.mul_dst   = DST_B;
                after_next    = S_E3;
                state_next    = S_WAIT;
            end
            S_E3:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_WYDY;
                cmd.mul_dst   = DST_B;
                cmd.mul_mode  = MODE_ADD;
                after_next    = S_E4;
                state_next    = S_WAIT;
            end
            S_E4:
            begin
                // A = squared length, B = dot product
                if (sts.b_le0 || sts.a_le0)
                    state_next = S_P0;
                else if (!sts.b_lt_a)
                    state_next = S_Q0;
                else
                    state_next = S_X0;
            end
            S_P0:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_WXWX;
                cmd.mul_dst   = DST_C;
                after_next    = S_P1;
                state_next    = S_WAIT;
            end
            S_P1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_WYWY;
                cmd.mul_dst   = DST_C;
                cmd.mul_mode  = MODE_ADD;
                after_next    = S_PCHK;
                state_next    = S_WAIT;
            end
            S_Q0:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_EXEX;
                cmd.mul_dst   = DST_C;
                after_next    = S_Q1;
                state_next    = S_WAIT;
            end
            S_Q1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_EYEY;
                cmd.mul_dst   = DST_C;
                cmd.mul_mode  = MODE_ADD;
                after_next    = S_PCHK;
                state_next    = S_WAIT;
            end
            S_X0:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_WXDY;
                cmd.mul_dst   = DST_C;
                after_next    = S_X1;
                state_next    = S_WAIT;
            end
            S_X1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_WYDX;
                cmd.mul_dst   = DST_C;
                cmd.mul_mode  = MODE_SUB;
                after_next    = S_X2;
                state_next    = S_WAIT;
            end
            S_X2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_CRCR;
                cmd.mul_dst   = DST_B;
                after_next    = S_X3;
                state_next    = S_WAIT;
            end
            S_X3:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = SEL_R2LEN;
                cmd.mul_dst   = DST_A;
                after_next    = S_X4;
                state_next    = S_WAIT;
            end
            S_X4:
                state_next = sts.a_lt_b ? S_NEXT : S_HIT;
            S_PCHK:
                state_next = sts.r2_lt_c ? S_NEXT : S_HIT;
            S_HIT:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_item.is_edge_hit = 1'b1;
                    out_item.edge_start  = i_reg[IDX_W-1:0];
                    out_item.edge_end    = j[IDX_W-1:0];
                    any_next             = 1'b1;
                    state_next           = S_NEXT;
                end
            end
            S_NEXT:
            begin
                i_next     = i_reg + 1'b1;
                state_next = S_LOOP;
            end
            S_VERD:
            begin
                if (out_free)
                begin
                    out_load               = 1'b1;
                    out_item.centre_inside = inside_reg;
                    out_item.collides      = inside_reg | any_reg;
                    out_item.overflowed    = ovf_reg;
                    out_item.last          = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            after_reg  <= S_IDLE;
            count_reg  <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            ovf_reg    <= 1'b0;
            phase_reg  <= 1'b0;
            inside_reg <= 1'b0;
            any_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            after_reg  <= after_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            ovf_reg    <= ovf_next;
            phase_reg  <= phase_next;
            inside_reg <= inside_next;
            any_reg    <= any_next;
        end
    end

endmodule

// ===== rtl/circle_polygon_collision.sv =====
// ----------------------------------------------------------------------------
// circle_polygon_collision
// Circle against polygon test: even-odd containment, then, if the centre lies outside, a per-edge hit walk.
// ----------------------------------------------------------------------------
// Clear and append words are taken back to back while idle; ready stays high after them.
// A test runs one 68-step shift-add multiplier for every product it needs.
// Test time grows with the vertex count, the products per edge, each edge hit
// and any output stall; the multiplier sets most of it.
// Reset (async, active low) empties the polygon and clears the overflow flag.
// Vertex storage holds no reset value; only appended entries are ever used.
module circle_polygon_collision import cpc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], coord_x[33:2], coord_y[65:34], radius[96:66], zero pad
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // edge_start[4:0], edge_end[9:5], centre_inside[10], collides[11],
    // overflowed[12], zero pad
    output logic [15:0]  m_axis_tdata,
    // is_edge_hit
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    dp_cmd_t   cmd;
    dp_sts_t   sts;
    out_item_t item, out_reg;
    logic      out_load, out_free;
    logic      ovalid_reg, ovalid_next;

    // single output register: takes a new word as soon as the old one leaves
    assign out_free = !ovalid_reg || m_axis_tready;

    cpc_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tdata[1:0]),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .out_load (out_load),
        .out_item (item),
        .cmd      (cmd),
        .sts      (sts)
    );

    cpc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .coord_x (s_axis_tdata[33:2]),
        .coord_y (s_axis_tdata[65:34]),
        .radius  (s_axis_tdata[96:66]),
        .sts     (sts)
    );

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_load)
            ovalid_next = 1'b1;
        else if (m_axis_tready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else
            ovalid_reg <= ovalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= item;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = out_reg.is_edge_hit;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {3'b000, out_reg.overflowed, out_reg.collides,
                            out_reg.centre_inside, out_reg.edge_end, out_reg.edge_start};

    // a new word is only loaded into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!ovalid_reg || m_axis_tready))
        else $error("output word overwritten");

    // the verdict is never flagged as an edge hit
    a_verdict_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser)
        else $error("verdict marked as edge hit");

    // no multiply completes while the block waits for a new word
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mul_done |-> !s_axis_tready)
        else $error("multiplier active while idle");

endmodule
